/* rtl/dq_pkg.sv */
`default_nettype none

package dq_pkg;

  // Ring store geometry
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } dq_op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } dq_status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic apply;
    logic read;
    logic load;
  } dq_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic out_busy;
  } dq_stat_t;

endpackage

`default_nettype wire

/* rtl/dq_if.sv */
`default_nettype none

interface dq_req_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic signed [dq_pkg::WORD_W-1:0]  value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface dq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [dq_pkg::WORD_W-1:0]  front_value;
  logic signed [dq_pkg::WORD_W-1:0]  back_value;
  logic [dq_pkg::COUNT_W-1:0]        count;
  logic                              is_empty;
  logic [1:0]                        status;

  modport source (output valid, output front_value, output back_value, output count,
                  output is_empty, output status, input ready);
  modport sink   (input valid, input front_value, input back_value, input count,
                  input is_empty, input status, output ready);
endinterface

`default_nettype wire

/* rtl/dq_ctrl.sv */
`default_nettype none

module dq_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire dq_pkg::dq_stat_t stat_i,
  output dq_pkg::dq_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_WRITE = 4'b0010,
    S_READ  = 4'b0100,
    S_LOAD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Sequence one request through write, read and load
  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.apply   = 1'b0;
    cmd_o.read    = 1'b0;
    cmd_o.load    = 1'b0;
    req_ready_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.apply = 1'b1;
        state_d     = S_READ;
      end
      S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = S_LOAD;
      end
      S_LOAD: begin
        // hold until the result register frees up
        if (!stat_i.out_busy) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !stat_i.out_busy)
    else $error("result loaded while previous result still pending");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("controller state is not one-hot");

  a_ready_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> state_q == S_IDLE)
    else $error("request taken outside idle");
`endif

endmodule

`default_nettype wire

/* rtl/dq_datapath.sv */
`default_nettype none

module dq_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic [1:0]                     req_kind_i,
  input  wire logic signed [dq_pkg::WORD_W-1:0] req_value_i,
  input  wire dq_pkg::dq_cmd_t                cmd_i,
  output dq_pkg::dq_stat_t                    stat_o,
  dq_rsp_if.source                            rsp_o
);

  localparam int IDX_W = dq_pkg::IDX_W;
  localparam int CNT_W = dq_pkg::CNT_W;

  // Fold a position below twice the depth back into the ring
  function automatic logic [IDX_W-1:0] ring_wrap(input logic [IDX_W:0] pos);
    logic [IDX_W:0] lim;
    lim = (IDX_W+1)'(dq_pkg::DEPTH);
    if (pos >= lim) begin
      return IDX_W'(pos - lim);
    end
    return IDX_W'(pos);
  endfunction

  logic [dq_pkg::WORD_W-1:0] slots_q [dq_pkg::DEPTH];

  logic [1:0]                  kind_q;
  logic [dq_pkg::WORD_W-1:0]   value_q;
  logic [IDX_W-1:0]            head_q, head_d;
  logic [CNT_W-1:0]            count_q, count_d;
  dq_pkg::dq_status_e          status_q, status_d;
  logic [dq_pkg::WORD_W-1:0]   front_rd_q, back_rd_q;

  logic                        out_valid_q;
  logic [dq_pkg::WORD_W-1:0]   out_front_q, out_back_q;
  logic [dq_pkg::COUNT_W-1:0]  out_count_q;
  logic                        out_empty_q;
  logic [1:0]                  out_status_q;

  logic                        full, empty, is_push;
  logic [IDX_W-1:0]            head_prev, head_next, tail_addr, back_addr;
  logic [IDX_W:0]              head_plus_cnt;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;

  assign full          = (count_q == CNT_W'(dq_pkg::DEPTH));
  assign empty         = (count_q == '0);
  assign is_push       = (dq_pkg::dq_op_e'(kind_q) == dq_pkg::OP_PUSH_FRONT) ||
                         (dq_pkg::dq_op_e'(kind_q) == dq_pkg::OP_PUSH_BACK);
  assign head_prev     = (head_q == '0) ? IDX_W'(dq_pkg::DEPTH - 1) : head_q - IDX_W'(1);
  assign head_next     = ring_wrap({1'b0, head_q} + (IDX_W+1)'(1));
  assign head_plus_cnt = {1'b0, head_q} + (IDX_W+1)'(count_q);
  assign tail_addr     = ring_wrap(head_plus_cnt);
  assign back_addr     = empty ? head_q : ring_wrap(head_plus_cnt - (IDX_W+1)'(1));

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= req_kind_i;
      value_q <= req_value_i;
    end
  end

  // Apply the operation to head, count and the slot write
  always_comb begin
    head_d   = head_q;
    count_d  = count_q;
    status_d = status_q;
    wr_en    = 1'b0;
    wr_addr  = tail_addr;
    if (cmd_i.apply) begin
      status_d = dq_pkg::ST_OK;
      case (dq_pkg::dq_op_e'(kind_q))
        dq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_d = dq_pkg::ST_PUSH_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = head_prev;
            head_d  = head_prev;
            count_d = count_q + CNT_W'(1);
          end
        end
        dq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_d = dq_pkg::ST_PUSH_FULL;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CNT_W'(1);
          end
        end
        dq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_d = dq_pkg::ST_POP_EMPTY;
          end else begin
            head_d  = head_next;
            count_d = count_q - CNT_W'(1);
          end
        end
        dq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_d = dq_pkg::ST_POP_EMPTY;
          end else begin
            count_d = count_q - CNT_W'(1);
          end
        end
        default: begin
          status_d = dq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q   <= '0;
      count_q  <= '0;
      status_q <= dq_pkg::ST_OK;
    end else begin
      head_q   <= head_d;
      count_q  <= count_d;
      status_q <= status_d;
    end
  end

  // Slot store: one write port, front and back read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slots_q[wr_addr] <= value_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      front_rd_q <= slots_q[head_q];
      back_rd_q  <= slots_q[back_addr];
    end
  end

  // Result register: load a new result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_front_q  <= empty ? '0 : front_rd_q;
      out_back_q   <= empty ? '0 : back_rd_q;
      out_count_q  <= dq_pkg::COUNT_W'(count_q);
      out_empty_q  <= empty;
      out_status_q <= status_q;
    end
  end

  assign stat_o.out_busy   = out_valid_q && !rsp_o.ready;
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.front_value = out_front_q;
  assign rsp_o.back_value  = out_back_q;
  assign rsp_o.count       = out_count_q;
  assign rsp_o.is_empty    = out_empty_q;
  assign rsp_o.status      = out_status_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(dq_pkg::DEPTH))
    else $error("element count exceeds depth");

  a_full_push_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.apply && is_push && full |=> $stable(count_q) && $stable(head_q))
    else $error("push on full queue changed the ring");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.is_empty |-> rsp_o.front_value == '0 && rsp_o.back_value == '0)
    else $error("empty result carries nonzero ends");
`endif

endmodule

`default_nettype wire

/* rtl/double_ended_queue.sv */
// Bounded double-ended queue of signed 32-bit words in a 16-slot ring.
// The result becomes valid after the controller sequence capture, write, registered
// slot read and result load; the load waits while the previous result is still pending,
// and a new request is taken only once the previous one has reached the result register.
// Reset clears head index, element count and the result valid; slots are not cleared.
`default_nettype none

module double_ended_queue (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  dq_req_if.sink    req_i,
  dq_rsp_if.source  rsp_o
);

  dq_pkg::dq_cmd_t  cmd;
  dq_pkg::dq_stat_t stat;
  logic             req_ready;

  assign req_i.ready = req_ready;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dq_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_kind_i  (req_i.kind),
    .req_value_i (req_i.value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_o       (rsp_o)
  );

endmodule

`default_nettype wire
